[rtl/lpr_pkg.sv]
// Shared constants, types and tables for the lidar range image projector.
// No dependencies; every other file imports this package.
package lpr_pkg;

    // Field widths
    localparam int COORD_BITS = 19;
    localparam int ROW_BITS   = 7;
    localparam int COL_BITS   = 12;
    localparam int DIST_W     = 19;

    // Square roots: root and radicand widths
    localparam int RT_W = COORD_BITS + 1;
    localparam int SQ_W = 2 * RT_W;
    localparam int DSAT_W = (RT_W > DIST_W) ? RT_W : DIST_W;
    localparam logic [DSAT_W-1:0] DIST_MAX = DSAT_W'((1 << DIST_W) - 1);

    // CORDIC
    localparam int CORDIC_STEPS = 23;
    localparam int FRAC   = 24;
    localparam int CW     = RT_W + FRAC + 2;
    localparam int ZW     = 25;
    localparam int ANG_W  = 16;
    localparam int VW     = 23;
    localparam int RCP_W  = 24;
    localparam int T0_W   = 13;
    localparam int RECIP_SH = 33;
    localparam logic [RCP_W-1:0] RECIP = RCP_W'(8589935);     // ceil(2^33 / 1000)
    localparam logic signed [ZW-1:0] ZCLAMP = ZW'(4500000);
    localparam logic [VW-1:0] RND = VW'(500);
    localparam logic [VW-1:0] ZCLAMP_RND = VW'(4500500);
    localparam logic signed [ANG_W-1:0] ANG_90  = ANG_W'(9000);
    localparam logic signed [ANG_W-1:0] ANG_180 = ANG_W'(18000);

    // atan(2^-i) in units of 1e-5 degree
    localparam logic signed [ZW-1:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
        25'sd4500000, 25'sd2656505, 25'sd1403624, 25'sd712502, 25'sd357633,
        25'sd178991, 25'sd89517, 25'sd44761, 25'sd22381, 25'sd11191,
        25'sd5595, 25'sd2798, 25'sd1399, 25'sd699, 25'sd350, 25'sd175,
        25'sd87, 25'sd44, 25'sd22, 25'sd11, 25'sd5, 25'sd3, 25'sd1
    };

    // Divider
    localparam int NUM_W = 16;
    localparam int DEN_W = 13;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VERT_RES   = 3'd0,
        REG_HORIZ_RES  = 3'd1,
        REG_BOTTOM_OFS = 3'd2,
        REG_MIN_RANGE  = 3'd3,
        REG_ROWS       = 3'd4,
        REG_COLS       = 3'd5
    } cfg_idx_t;

    localparam logic [11:0] VERT_RES_RST   = 12'd200;
    localparam logic [11:0] HORIZ_RES_RST  = 12'd20;
    localparam logic [13:0] BOTTOM_OFS_RST = 14'd1510;
    localparam logic [18:0] MIN_RANGE_RST  = 19'd1000;
    localparam logic [7:0]  ROWS_RST       = 8'd16;
    localparam logic [12:0] COLS_RST       = 13'd1800;

    typedef enum logic [1:0] {
        ST_KEPT      = 2'd0,
        ST_ROW_OUT   = 2'd1,
        ST_COL_OUT   = 2'd2,
        ST_TOO_CLOSE = 2'd3
    } status_t;

    // Side data that rides along the CORDIC and divider pipelines
    typedef struct packed {
        logic [RT_W-1:0] dist_mm;
        logic            rsum_neg;
        logic            q_neg;
    } meta_t;

endpackage

[rtl/lpr_point_if.sv]
// Point channel: valid/ready handshake carrying one lidar point.
// Depends on lpr_pkg.
interface lpr_point_if;
    import lpr_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;

    modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

[rtl/lpr_range_if.sv]
// Result channel: valid/ready handshake carrying one projected point.
// Depends on lpr_pkg.
interface lpr_range_if;
    import lpr_pkg::*;

    logic                valid;
    logic                ready;
    logic [ROW_BITS-1:0] row_index;
    logic [COL_BITS-1:0] col_index;
    logic [DIST_W-1:0]   distance_mm;
    logic [1:0]          status;

    modport source (output valid, output row_index, output col_index, output distance_mm,
                    output status, input ready);
    modport sink   (input valid, input row_index, input col_index, input distance_mm,
                    input status, output ready);
endinterface

[rtl/lidar_point_to_range_image_top.sv]
// Lidar point to spherical range image projector, top level.
// Accepts one point per cycle, sustained while the result side keeps up.
// The whole pipeline advances together whenever the output register is empty or taken,
// so throughput is one item per clock while the result side keeps up.
// Reset (rst_n, async, active low) clears all valid bits and loads the register defaults.
// Depends on lpr_pkg, lpr_point_if, lpr_range_if, lpr_cordic and lpr_div.
module lidar_point_to_range_image_top (
    input  logic                          clk,
    input  logic                          rst_n,
    lpr_point_if.sink                     pts,
    lpr_range_if.source                   res,
    input  logic                          wr_en,
    input  logic [lpr_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [lpr_pkg::CFG_DATA_W-1:0] wr_data
);
    import lpr_pkg::*;

    localparam int C_W = NUM_W + 2;
    localparam logic [NUM_W-1:0] ROW_CAP = NUM_W'(1 << ROW_BITS);
    localparam logic signed [C_W-1:0] COL_CAP = C_W'(1 << COL_BITS);
    localparam logic signed [ANG_W:0] Q_OFS = (ANG_W+1)'(9000);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [11:0] vert_res_reg;
    logic [11:0] horiz_res_reg;
    logic [13:0] bottom_ofs_reg;
    logic [18:0] min_range_reg;
    logic [7:0]  rows_reg;
    logic [12:0] cols_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vert_res_reg   <= VERT_RES_RST;
            horiz_res_reg  <= HORIZ_RES_RST;
            bottom_ofs_reg <= BOTTOM_OFS_RST;
            min_range_reg  <= MIN_RANGE_RST;
            rows_reg       <= ROWS_RST;
            cols_reg       <= COLS_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_VERT_RES:   vert_res_reg   <= wr_data[11:0];
                REG_HORIZ_RES:  horiz_res_reg  <= wr_data[11:0];
                REG_BOTTOM_OFS: bottom_ofs_reg <= wr_data[13:0];
                REG_MIN_RANGE:  min_range_reg  <= wr_data[18:0];
                REG_ROWS:       rows_reg       <= wr_data[7:0];
                REG_COLS:       cols_reg       <= wr_data[12:0];
                default:        ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Global advance: every stage moves when the output slot frees up
    // ---------------------------------------------------------------
    logic adv;
    logic res_vld_reg;

    assign adv       = !res_vld_reg || res.ready;
    assign pts.ready = adv;

    // ---------------------------------------------------------------
    // Stage 1: capture point, take magnitudes
    // ---------------------------------------------------------------
    logic                         s1_vld_reg;
    logic signed [COORD_BITS-1:0] s1_x_reg, s1_y_reg, s1_z_reg;
    logic [COORD_BITS-1:0]        s1_ax_reg, s1_ay_reg, s1_az_reg;

    // Stage 2: squares
    logic                         s2_vld_reg;
    logic signed [COORD_BITS-1:0] s2_x_reg, s2_y_reg, s2_z_reg;
    logic [2*COORD_BITS-1:0]      s2_sx_reg, s2_sy_reg, s2_sz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= pts.valid;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_x_reg  <= pts.pos_x;
            s1_y_reg  <= pts.pos_y;
            s1_z_reg  <= pts.pos_z;
            s1_ax_reg <= pts.pos_x[COORD_BITS-1] ? COORD_BITS'(-pts.pos_x)
                                                 : COORD_BITS'(pts.pos_x);
            s1_ay_reg <= pts.pos_y[COORD_BITS-1] ? COORD_BITS'(-pts.pos_y)
                                                 : COORD_BITS'(pts.pos_y);
            s1_az_reg <= pts.pos_z[COORD_BITS-1] ? COORD_BITS'(-pts.pos_z)
                                                 : COORD_BITS'(pts.pos_z);
            s2_x_reg  <= s1_x_reg;
            s2_y_reg  <= s1_y_reg;
            s2_z_reg  <= s1_z_reg;
            s2_sx_reg <= {{COORD_BITS{1'b0}}, s1_ax_reg} * {{COORD_BITS{1'b0}}, s1_ax_reg};
            s2_sy_reg <= {{COORD_BITS{1'b0}}, s1_ay_reg} * {{COORD_BITS{1'b0}}, s1_ay_reg};
            s2_sz_reg <= {{COORD_BITS{1'b0}}, s1_az_reg} * {{COORD_BITS{1'b0}}, s1_az_reg};
        end
    end

    // ---------------------------------------------------------------
    // Stage 3 and square-root pipeline. Entry 0 holds x^2+y^2 and
    // x^2+y^2+z^2; each later entry settles one root bit, MSB first.
    // ---------------------------------------------------------------
    logic                         sq_vld_reg   [0:RT_W];
    logic [SQ_W-1:0]              sq_remh_reg  [0:RT_W];
    logic [RT_W-1:0]              sq_rooth_reg [0:RT_W];
    logic [SQ_W-1:0]              sq_remd_reg  [0:RT_W];
    logic [RT_W-1:0]              sq_rootd_reg [0:RT_W];
    logic signed [COORD_BITS-1:0] sq_x_reg [0:RT_W];
    logic signed [COORD_BITS-1:0] sq_y_reg [0:RT_W];
    logic signed [COORD_BITS-1:0] sq_z_reg [0:RT_W];
    logic [SQ_W-1:0]              hsq;

    assign hsq = SQ_W'(s2_sx_reg) + SQ_W'(s2_sy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_vld_reg[0] <= 1'b0;
        else if (adv)
            sq_vld_reg[0] <= s2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_remh_reg[0]  <= hsq;
            sq_rooth_reg[0] <= '0;
            sq_remd_reg[0]  <= hsq + SQ_W'(s2_sz_reg);
            sq_rootd_reg[0] <= '0;
            sq_x_reg[0]     <= s2_x_reg;
            sq_y_reg[0]     <= s2_y_reg;
            sq_z_reg[0]     <= s2_z_reg;
        end
    end

    for (genvar k = 0; k < RT_W; k++) begin : g_sqrt
        localparam int B = RT_W - 1 - k;
        logic [SQ_W-1:0] cand_h;
        logic [SQ_W-1:0] cand_d;

        // (root + 2^B)^2 - root^2
        always_comb
        begin
            cand_h = (SQ_W'(sq_rooth_reg[k]) << (B + 1)) | (SQ_W'(1) << (2 * B));
            cand_d = (SQ_W'(sq_rootd_reg[k]) << (B + 1)) | (SQ_W'(1) << (2 * B));
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_vld_reg[k+1] <= 1'b0;
            else if (adv)
                sq_vld_reg[k+1] <= sq_vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (sq_remh_reg[k] >= cand_h)
                begin
                    sq_remh_reg[k+1]  <= sq_remh_reg[k] - cand_h;
                    sq_rooth_reg[k+1] <= sq_rooth_reg[k] | (RT_W'(1) << B);
                end
                else
                begin
                    sq_remh_reg[k+1]  <= sq_remh_reg[k];
                    sq_rooth_reg[k+1] <= sq_rooth_reg[k];
                end
                if (sq_remd_reg[k] >= cand_d)
                begin
                    sq_remd_reg[k+1]  <= sq_remd_reg[k] - cand_d;
                    sq_rootd_reg[k+1] <= sq_rootd_reg[k] | (RT_W'(1) << B);
                end
                else
                begin
                    sq_remd_reg[k+1]  <= sq_remd_reg[k];
                    sq_rootd_reg[k+1] <= sq_rootd_reg[k];
                end
                sq_x_reg[k+1] <= sq_x_reg[k];
                sq_y_reg[k+1] <= sq_y_reg[k];
                sq_z_reg[k+1] <= sq_z_reg[k];
            end
        end
    end

    // ---------------------------------------------------------------
    // Angles: elevation atan2(z, h), azimuth atan2(x, y)
    // ---------------------------------------------------------------
    meta_t                   cd_meta_in;
    logic                    cd_vld;
    logic signed [ANG_W-1:0] elev;
    logic signed [ANG_W-1:0] azim;
    meta_t                   cd_meta;

    assign cd_meta_in = '{dist_mm: sq_rootd_reg[RT_W], rsum_neg: 1'b0, q_neg: 1'b0};

    lpr_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sq_vld_reg[RT_W]),
        .elev_n    ($signed({{2{sq_z_reg[RT_W][COORD_BITS-1]}}, sq_z_reg[RT_W]})),
        .elev_d    ($signed({1'b0, sq_rooth_reg[RT_W]})),
        .azim_n    ($signed({{2{sq_x_reg[RT_W][COORD_BITS-1]}}, sq_x_reg[RT_W]})),
        .azim_d    ($signed({{2{sq_y_reg[RT_W][COORD_BITS-1]}}, sq_y_reg[RT_W]})),
        .meta_in   (cd_meta_in),
        .out_valid (cd_vld),
        .elev      (elev),
        .azim      (azim),
        .meta_out  (cd_meta)
    );

    // ---------------------------------------------------------------
    // Divider operands. Row: (elev + offset) / vert_res. Column:
    // round-half-away |q| / hr = (2|q| + hr) / (2 hr), q = azim - 90 deg.
    // ---------------------------------------------------------------
    logic signed [ANG_W:0] rsum;
    logic signed [ANG_W:0] qv;
    logic [NUM_W-1:0]      aq;
    logic [NUM_W-1:0]      col_num;
    meta_t                 dv_meta_in;

    always_comb
    begin
        rsum    = (ANG_W+1)'(elev) + $signed({3'b000, bottom_ofs_reg});
        qv      = (ANG_W+1)'(azim) - Q_OFS;
        aq      = qv[ANG_W] ? NUM_W'(-qv) : NUM_W'(qv);
        col_num = NUM_W'({aq, 1'b0}) + NUM_W'(horiz_res_reg);
        dv_meta_in = '{dist_mm: cd_meta.dist_mm, rsum_neg: rsum[ANG_W], q_neg: qv[ANG_W]};
    end

    logic             dv_vld;
    logic [NUM_W-1:0] row_quo;
    logic [NUM_W-1:0] col_quo;
    meta_t            dv_meta;

    lpr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (cd_vld),
        .row_num   (NUM_W'(rsum)),
        .row_den   ({1'b0, vert_res_reg}),
        .col_num   (col_num),
        .col_den   ({horiz_res_reg, 1'b0}),
        .meta_in   (dv_meta_in),
        .out_valid (dv_vld),
        .row_quo   (row_quo),
        .col_quo   (col_quo),
        .meta_out  (dv_meta)
    );

    // ---------------------------------------------------------------
    // E1: row check, raw column cols/2 -/+ quotient
    // ---------------------------------------------------------------
    logic                 e1_vld_reg;
    logic                 e1_row_fail_reg;
    logic [ROW_BITS-1:0]  e1_row_reg;
    logic signed [C_W-1:0] e1_c_reg;
    logic                 e1_hr0_reg;
    logic [RT_W-1:0]      e1_dist_reg;
    logic signed [C_W-1:0] half_cols;

    assign half_cols = $signed(C_W'(cols_reg >> 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e1_vld_reg <= 1'b0;
        else if (adv)
            e1_vld_reg <= dv_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_row_fail_reg <= dv_meta.rsum_neg || (vert_res_reg == '0) ||
                               (row_quo >= NUM_W'(rows_reg)) || (row_quo >= ROW_CAP);
            e1_row_reg      <= row_quo[ROW_BITS-1:0];
            e1_c_reg        <= dv_meta.q_neg ? half_cols + $signed(C_W'(col_quo))
                                             : half_cols - $signed(C_W'(col_quo));
            e1_hr0_reg      <= (horiz_res_reg == '0);
            e1_dist_reg     <= dv_meta.dist_mm;
        end
    end

    // ---------------------------------------------------------------
    // E2: wrap column, final checks, status priority, output register
    // ---------------------------------------------------------------
    logic signed [C_W-1:0] cols_s;
    logic signed [C_W-1:0] c_wrap;
    logic                  col_fail;
    logic                  too_close;
    status_t               st_next;
    logic [DSAT_W-1:0]     dist_ext;

    logic [ROW_BITS-1:0]   res_row_reg;
    logic [COL_BITS-1:0]   res_col_reg;
    logic [DIST_W-1:0]     res_dist_reg;
    status_t               res_st_reg;

    always_comb
    begin
        cols_s    = $signed(C_W'(cols_reg));
        c_wrap    = (e1_c_reg >= cols_s) ? e1_c_reg - cols_s : e1_c_reg;
        col_fail  = e1_hr0_reg || (c_wrap < 0) || (c_wrap >= cols_s) || (c_wrap >= COL_CAP);
        too_close = (e1_dist_reg < RT_W'(min_range_reg));
        dist_ext  = DSAT_W'(e1_dist_reg);
        priority if (e1_row_fail_reg)
            st_next = ST_ROW_OUT;
        else if (col_fail)
            st_next = ST_COL_OUT;
        else if (too_close)
            st_next = ST_TOO_CLOSE;
        else
            st_next = ST_KEPT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_vld_reg <= 1'b0;
        else if (adv)
            res_vld_reg <= e1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_st_reg   <= st_next;
            res_row_reg  <= (st_next == ST_KEPT) ? e1_row_reg : '0;
            res_col_reg  <= (st_next == ST_KEPT) ? c_wrap[COL_BITS-1:0] : '0;
            res_dist_reg <= (dist_ext > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(dist_ext);
        end
    end

    assign res.valid       = res_vld_reg;
    assign res.row_index   = res_row_reg;
    assign res.col_index   = res_col_reg;
    assign res.distance_mm = res_dist_reg;
    assign res.status      = res_st_reg;

endmodule

[rtl/lpr_cordic.sv]
// Two-lane pipelined atan2 in centidegrees (elevation and azimuth lanes).
// Octant reduction, 23 vectoring CORDIC stages, rounding by reciprocal. Uses lpr_pkg.
module lpr_cordic (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     in_valid,
    input  logic signed [lpr_pkg::RT_W:0] elev_n,
    input  logic signed [lpr_pkg::RT_W:0] elev_d,
    input  logic signed [lpr_pkg::RT_W:0] azim_n,
    input  logic signed [lpr_pkg::RT_W:0] azim_d,
    input  lpr_pkg::meta_t           meta_in,
    output logic                     out_valid,
    output logic signed [lpr_pkg::ANG_W-1:0] elev,
    output logic signed [lpr_pkg::ANG_W-1:0] azim,
    output lpr_pkg::meta_t           meta_out
);
    import lpr_pkg::*;

    localparam int LAST = CORDIC_STEPS + 3;

    typedef struct packed {
        logic swap;
        logic dneg;
        logic nneg;
        logic zero;
    } oct_t;

    logic signed [RT_W:0]   pn [0:1];
    logic signed [RT_W:0]   pd [0:1];
    logic signed [CW-1:0]   cx_reg [0:1][0:CORDIC_STEPS];
    logic signed [CW-1:0]   cy_reg [0:1][0:CORDIC_STEPS];
    logic signed [ZW-1:0]   cz_reg [0:1][0:CORDIC_STEPS];
    oct_t                   oct_reg [0:1][0:CORDIC_STEPS+2];
    logic                   vld_reg [0:LAST];
    meta_t                  meta_reg [0:LAST];
    logic [VW-1:0]          p1_v_reg [0:1];
    logic [VW+RCP_W-1:0]    p2_prod_reg [0:1];
    logic signed [ANG_W-1:0] ang_reg [0:1];

    assign pn[0] = elev_n;
    assign pd[0] = elev_d;
    assign pn[1] = azim_n;
    assign pd[1] = azim_d;

    // valid and side data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (adv)
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            meta_reg[0] <= meta_in;
    end

    for (genvar k = 0; k < LAST; k++) begin : g_ctl
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else if (adv)
                vld_reg[k+1] <= vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                meta_reg[k+1] <= meta_reg[k];
        end
    end

    for (genvar ln = 0; ln < 2; ln++) begin : g_lane
        logic [RT_W-1:0] a_abs;
        logic [RT_W-1:0] b_abs;
        logic [RT_W-1:0] l_val;
        logic [RT_W-1:0] s_val;
        logic [T0_W-1:0] t0;
        logic signed [ANG_W-1:0] t_ang;

        // octant reduction: larger over smaller
        always_comb
        begin
            a_abs = pn[ln][RT_W] ? RT_W'(-pn[ln]) : RT_W'(pn[ln]);
            b_abs = pd[ln][RT_W] ? RT_W'(-pd[ln]) : RT_W'(pd[ln]);
            l_val = (a_abs > b_abs) ? a_abs : b_abs;
            s_val = (a_abs > b_abs) ? b_abs : a_abs;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cx_reg[ln][0] <= $signed({2'b00, l_val, {FRAC{1'b0}}});
                cy_reg[ln][0] <= $signed({2'b00, s_val, {FRAC{1'b0}}});
                cz_reg[ln][0] <= '0;
                oct_reg[ln][0] <= '{swap: (a_abs > b_abs), dneg: pd[ln][RT_W],
                                    nneg: pn[ln][RT_W],
                                    zero: (a_abs == '0) && (b_abs == '0)};
            end
        end

        for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (!cy_reg[ln][k][CW-1])
                    begin
                        cx_reg[ln][k+1] <= cx_reg[ln][k] + (cy_reg[ln][k] >>> k);
                        cy_reg[ln][k+1] <= cy_reg[ln][k] - (cx_reg[ln][k] >>> k);
                        cz_reg[ln][k+1] <= cz_reg[ln][k] + ATAN_TAB[k];
                    end
                    else
                    begin
                        cx_reg[ln][k+1] <= cx_reg[ln][k] - (cy_reg[ln][k] >>> k);
                        cy_reg[ln][k+1] <= cy_reg[ln][k] + (cx_reg[ln][k] >>> k);
                        cz_reg[ln][k+1] <= cz_reg[ln][k] - ATAN_TAB[k];
                    end
                    oct_reg[ln][k+1] <= oct_reg[ln][k];
                end
            end
        end

        // clamp, round, scale to centidegrees, unfold octant
        always_comb
        begin
            t0 = p2_prod_reg[ln][RECIP_SH +: T0_W];
            t_ang = $signed(ANG_W'(t0));
            if (oct_reg[ln][CORDIC_STEPS+2].swap)
                t_ang = ANG_90 - t_ang;
            if (oct_reg[ln][CORDIC_STEPS+2].dneg)
                t_ang = ANG_180 - t_ang;
            if (oct_reg[ln][CORDIC_STEPS+2].nneg)
                t_ang = -t_ang;
            if (oct_reg[ln][CORDIC_STEPS+2].zero)
                t_ang = '0;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (cz_reg[ln][CORDIC_STEPS] < 0)
                    p1_v_reg[ln] <= RND;
                else if (cz_reg[ln][CORDIC_STEPS] > ZCLAMP)
                    p1_v_reg[ln] <= ZCLAMP_RND;
                else
                    p1_v_reg[ln] <= VW'(cz_reg[ln][CORDIC_STEPS]) + RND;
                oct_reg[ln][CORDIC_STEPS+1] <= oct_reg[ln][CORDIC_STEPS];
                p2_prod_reg[ln] <= {{RCP_W{1'b0}}, p1_v_reg[ln]} * {{VW{1'b0}}, RECIP};
                oct_reg[ln][CORDIC_STEPS+2] <= oct_reg[ln][CORDIC_STEPS+1];
                ang_reg[ln] <= t_ang;
            end
        end
    end

    assign out_valid = vld_reg[LAST];
    assign meta_out  = meta_reg[LAST];
    assign elev      = ang_reg[0];
    assign azim      = ang_reg[1];

endmodule

[rtl/lpr_div.sv]
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Row lane and column lane share the stage timing. Uses lpr_pkg.
module lpr_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_valid,
    input  logic [lpr_pkg::NUM_W-1:0]   row_num,
    input  logic [lpr_pkg::DEN_W-1:0]   row_den,
    input  logic [lpr_pkg::NUM_W-1:0]   col_num,
    input  logic [lpr_pkg::DEN_W-1:0]   col_den,
    input  lpr_pkg::meta_t              meta_in,
    output logic                        out_valid,
    output logic [lpr_pkg::NUM_W-1:0]   row_quo,
    output logic [lpr_pkg::NUM_W-1:0]   col_quo,
    output lpr_pkg::meta_t              meta_out
);
    import lpr_pkg::*;

    logic [NUM_W-1:0] num [0:1];
    logic [DEN_W-1:0] den [0:1];
    logic [NUM_W-1:0] dn_reg [0:1][0:NUM_W];
    logic [DEN_W-1:0] dd_reg [0:1][0:NUM_W];
    logic [DEN_W-1:0] dr_reg [0:1][0:NUM_W];
    logic [NUM_W-1:0] dq_reg [0:1][0:NUM_W];
    logic             vld_reg [0:NUM_W];
    meta_t            meta_reg [0:NUM_W];

    assign num[0] = row_num;
    assign den[0] = row_den;
    assign num[1] = col_num;
    assign den[1] = col_den;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (adv)
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            meta_reg[0] <= meta_in;
    end

    for (genvar ln = 0; ln < 2; ln++) begin : g_in
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dn_reg[ln][0] <= num[ln];
                dd_reg[ln][0] <= den[ln];
                dr_reg[ln][0] <= '0;
                dq_reg[ln][0] <= '0;
            end
        end
    end

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        localparam int B = NUM_W - 1 - k;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else if (adv)
                vld_reg[k+1] <= vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                meta_reg[k+1] <= meta_reg[k];
        end

        for (genvar ln = 0; ln < 2; ln++) begin : g_lane
            logic [DEN_W:0] trial;
            logic           ge;

            always_comb
            begin
                trial = {dr_reg[ln][k], dn_reg[ln][k][B]};
                ge    = (trial >= {1'b0, dd_reg[ln][k]});
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dn_reg[ln][k+1] <= dn_reg[ln][k];
                    dd_reg[ln][k+1] <= dd_reg[ln][k];
                    dr_reg[ln][k+1] <= ge ? DEN_W'(trial - {1'b0, dd_reg[ln][k]})
                                          : DEN_W'(trial);
                    dq_reg[ln][k+1] <= dq_reg[ln][k] | (NUM_W'(ge) << B);
                end
            end
        end
    end

    assign out_valid = vld_reg[NUM_W];
    assign meta_out  = meta_reg[NUM_W];
    assign row_quo   = dq_reg[0][NUM_W];
    assign col_quo   = dq_reg[1][NUM_W];

endmodule
